FILE: src/lzw_pkg.sv
// Package with the constants, item types and slot layout of the LZW compressor.
`default_nettype none
package lzw_pkg;

    localparam int CODE_BITS    = 13;
    localparam int HASH_SIZE    = 9001;
    localparam int RESTART_CODE = 256;
    localparam int FIRST_FREE   = 257;
    localparam int CODE_LIMIT   = (1 << CODE_BITS) - 1;
    localparam int MAX_RESULTS  = 8;

    function automatic int hash_shift_f();
        int fc;
        int j;
        fc = HASH_SIZE;
        j  = 0;
        for (int i = 0; i < 16; i++) begin
            if (fc < 65536) begin
                fc = fc * 2;
                j  = j + 1;
            end
        end
        return (j >= 8) ? 0 : 8 - j;
    endfunction

    function automatic int max3_f(int a, int b, int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    localparam int HASH_SHIFT = hash_shift_f();
    localparam int IDX_W  = $clog2(HASH_SIZE);
    localparam int KEY_W  = CODE_BITS + 8;
    localparam int HV_W   = max3_f(8 + HASH_SHIFT, CODE_BITS, IDX_W + 1);
    localparam int ACC_W  = CODE_BITS + 7;
    localparam int CNT_W  = $clog2(CODE_BITS + 8);
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
    localparam int PRB_W  = $clog2(HASH_SIZE + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [CODE_BITS-1:0] code;
    } slot_t;

endpackage
`default_nettype wire

FILE: src/lzw_slot_ram.sv
// Single-port-write, single-port-read dictionary memory with registered read data.
`default_nettype none
module lzw_slot_ram (
    input  wire logic                      aclk,
    input  wire logic                      rd_en,
    input  wire logic [lzw_pkg::IDX_W-1:0] rd_addr,
    output lzw_pkg::slot_t                 rd_data,
    input  wire logic                      wr_en,
    input  wire logic [lzw_pkg::IDX_W-1:0] wr_addr,
    input  wire lzw_pkg::slot_t            wr_data
);
    import lzw_pkg::*;

    slot_t mem [HASH_SIZE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/lzw_compressor_fixed_code.sv
// LZW compressor top level: 13-bit fixed codes, hashed dictionary in one memory.
//
// The input channel (s_valid, s_ready, s_data) takes one uncompressed byte per
// item; end_of_stream marks the last byte of a stream. The output channel
// (m_valid, m_ready, m_data) delivers packed code bytes, MSB first, with
// out_last set on the final byte produced for an input item.
// One item is worked on at a time. A dictionary hit passes through the states
// idle, hash, read, check, next and finish, plus one more hash step when the
// home slot lies beyond the table. The first byte of a stream goes from idle
// straight to next and finish. Each collision probe adds a read and a check.
// The code sent on a miss adds an emit and a drain step, each further code a
// next, emit and drain step, plus a drain step for each output byte; padding
// the last partial byte adds a pad step. After reset, and whenever the
// dictionary is cleared (codes run out or end of stream), a clearing pass
// writes all 9001 slots, one per cycle, while s_ready stays low until it ends.
// When the receiver stalls, the packer holds at most one byte back plus the
// output register, then waits; no byte is lost.
`default_nettype none
module lzw_compressor_fixed_code (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire lzw_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output lzw_pkg::out_t     m_data
);
    import lzw_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HASH, S_RD, S_CHK, S_NEXT, S_EMIT, S_DRAIN, S_PAD, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE, PH_MISS, PH_CLR, PH_EOSP, PH_TERM
    } phase_t;

    state_t               state_reg;
    phase_t               ph_reg;
    in_t                  in_reg;
    logic [CODE_BITS-1:0] prefix_reg;
    logic                 awaiting_reg;
    logic [CODE_BITS-1:0] nfc_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [HV_W-1:0]      h_reg;
    logic [HV_W-1:0]      disp_reg;
    logic [PRB_W-1:0]     prb_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic                 clr_pend_reg;
    logic                 wipe_reg;
    logic [7:0]           hold_reg;
    logic                 hold_v_reg;
    logic                 mv_reg;
    out_t                 mdata_reg;
    logic [RCNT_W-1:0]    rcnt_reg;
    logic [IDX_W-1:0]     clr_idx_reg;

    slot_t            rd_data;
    slot_t            wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] key;
    logic [HV_W-1:0]  hv0;
    logic [HV_W-1:0]  nxt_idx;
    logic [CNT_W-1:0] dsh;
    logic [7:0]       pbyte;
    logic             out_free;
    logic             push_ok;
    logic             push_req;
    logic             push_do;
    logic             out_load;
    logic             out_last_n;
    logic             hit;
    logic             probe_more;
    logic             add_slot;

    lzw_slot_ram u_ram (
        .aclk    (aclk),
        .rd_en   (state_reg == S_RD),
        .rd_addr (h_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb begin
        key        = {prefix_reg, in_reg.data_byte};
        hv0        = (HV_W'(s_data.data_byte) << HASH_SHIFT) ^ HV_W'(prefix_reg);
        nxt_idx    = (h_reg >= disp_reg) ? h_reg - disp_reg
                                         : h_reg + (HV_W'(HASH_SIZE) - disp_reg);
        hit        = rd_data.valid && (rd_data.key == key);
        probe_more = rd_data.valid && ((prb_reg + PRB_W'(1)) < PRB_W'(HASH_SIZE));
        add_slot   = !hit && !probe_more && !rd_data.valid
                     && (nfc_reg < CODE_BITS'(CODE_LIMIT));
        dsh        = cnt_reg - CNT_W'(8);
        if (state_reg == S_PAD) begin
            pbyte = 8'(acc_reg << (CNT_W'(8) - cnt_reg));
        end else begin
            pbyte = 8'(acc_reg >> dsh);
        end
        out_free = !mv_reg || m_ready;
        push_ok  = !hold_v_reg || out_free;
        push_req = push_ok && (((state_reg == S_DRAIN) && (cnt_reg >= CNT_W'(8)))
                            || ((state_reg == S_PAD) && (cnt_reg != '0)));
        push_do  = push_req && (rcnt_reg < RCNT_W'(MAX_RESULTS));
        out_load   = 1'b0;
        out_last_n = 1'b0;
        if (push_do && hold_v_reg) begin
            out_load = 1'b1;
        end
        if ((state_reg == S_FIN) && hold_v_reg && out_free) begin
            out_load   = 1'b1;
            out_last_n = 1'b1;
        end
        if (state_reg == S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end else begin
            wr_en         = (state_reg == S_CHK) && add_slot;
            wr_addr       = h_reg[IDX_W-1:0];
            wr_data.valid = 1'b1;
            wr_data.key   = key;
            wr_data.code  = nfc_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = mdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            ph_reg       <= PH_NONE;
            prefix_reg   <= '0;
            awaiting_reg <= 1'b1;
            nfc_reg      <= CODE_BITS'(FIRST_FREE);
            acc_reg      <= '0;
            cnt_reg      <= '0;
            clr_pend_reg <= 1'b0;
            wipe_reg     <= 1'b0;
            hold_v_reg   <= 1'b0;
            mv_reg       <= 1'b0;
            rcnt_reg     <= '0;
            clr_idx_reg  <= '0;
        end else begin
            if (out_load) begin
                mdata_reg <= '{out_byte: hold_reg, out_last: out_last_n};
                mv_reg    <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (push_do) begin
                hold_reg   <= pbyte;
                hold_v_reg <= 1'b1;
                rcnt_reg   <= rcnt_reg + RCNT_W'(1);
            end
            case (state_reg)
                S_CLR: begin
                    if (clr_idx_reg == IDX_W'(HASH_SIZE - 1)) begin
                        wipe_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg   <= s_data;
                        rcnt_reg <= '0;
                        ph_reg   <= PH_NONE;
                        if (awaiting_reg) begin
                            prefix_reg   <= CODE_BITS'(s_data.data_byte);
                            awaiting_reg <= 1'b0;
                            state_reg    <= S_NEXT;
                        end else begin
                            h_reg     <= hv0;
                            prb_reg   <= '0;
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (h_reg >= HV_W'(HASH_SIZE)) begin
                        h_reg <= h_reg - HV_W'(HASH_SIZE);
                    end else begin
                        disp_reg  <= (h_reg == '0) ? HV_W'(1) : HV_W'(HASH_SIZE) - h_reg;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    if (hit) begin
                        prefix_reg <= rd_data.code;
                        state_reg  <= S_NEXT;
                    end else if (probe_more) begin
                        prb_reg   <= prb_reg + PRB_W'(1);
                        h_reg     <= nxt_idx;
                        state_reg <= S_RD;
                    end else begin
                        code_reg   <= prefix_reg;
                        prefix_reg <= CODE_BITS'(in_reg.data_byte);
                        ph_reg     <= PH_MISS;
                        if (nfc_reg < CODE_BITS'(CODE_LIMIT)) begin
                            if (!rd_data.valid) begin
                                nfc_reg <= nfc_reg + CODE_BITS'(1);
                            end
                        end else begin
                            clr_pend_reg <= 1'b1;
                            wipe_reg     <= 1'b1;
                            nfc_reg      <= CODE_BITS'(FIRST_FREE);
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    acc_reg   <= (acc_reg << CODE_BITS) | ACC_W'(code_reg);
                    cnt_reg   <= cnt_reg + CNT_W'(CODE_BITS);
                    state_reg <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (cnt_reg >= CNT_W'(8)) begin
                        if (push_ok) begin
                            acc_reg <= acc_reg & ((ACC_W'(1) << dsh) - ACC_W'(1));
                            cnt_reg <= dsh;
                        end
                    end else begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if ((ph_reg == PH_MISS) && clr_pend_reg) begin
                        code_reg     <= CODE_BITS'(RESTART_CODE);
                        ph_reg       <= PH_CLR;
                        clr_pend_reg <= 1'b0;
                        state_reg    <= S_EMIT;
                    end else if (in_reg.end_of_stream && ((ph_reg == PH_NONE)
                                 || (ph_reg == PH_MISS) || (ph_reg == PH_CLR))) begin
                        code_reg  <= prefix_reg;
                        ph_reg    <= PH_EOSP;
                        state_reg <= S_EMIT;
                    end else if (ph_reg == PH_EOSP) begin
                        code_reg  <= CODE_BITS'(CODE_LIMIT);
                        ph_reg    <= PH_TERM;
                        state_reg <= S_EMIT;
                    end else if (ph_reg == PH_TERM) begin
                        state_reg <= S_PAD;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_PAD: begin
                    if (cnt_reg == '0) begin
                        state_reg <= S_FIN;
                    end else if (push_ok) begin
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!hold_v_reg || out_free) begin
                        if (hold_v_reg) begin
                            hold_v_reg <= 1'b0;
                        end
                        clr_idx_reg <= '0;
                        if (in_reg.end_of_stream) begin
                            prefix_reg   <= '0;
                            awaiting_reg <= 1'b1;
                            nfc_reg      <= CODE_BITS'(FIRST_FREE);
                            acc_reg      <= '0;
                            cnt_reg      <= '0;
                            wipe_reg     <= 1'b1;
                            state_reg    <= S_CLR;
                        end else if (wipe_reg) begin
                            state_reg <= S_CLR;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_CLR;
                end
            endcase
        end
    end

    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !hold_v_reg)
        else $error("A byte is still held back while new items are taken.");

    a_rcnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= RCNT_W'(MAX_RESULTS))
        else $error("More bytes than allowed for one item.");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (h_reg < HV_W'(HASH_SIZE)))
        else $error("Dictionary read outside the table.");

    a_clear_after_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) && clr_pend_reg |-> 1'b0)
        else $error("Clear code was not emitted before the item ended.");

endmodule
`default_nettype wire
